/* hw/rtl/fifo_queue_with_delete_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the FIFO queue with delete
// Shorthand for clocked implication checks with synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_DELETE_MACROS_SVH
`define FIFO_QUEUE_WITH_DELETE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FQD_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fqd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FQD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fqd assertion failed");

`endif

/* hw/rtl/fqd_pkg.sv */
// ----------------------------------------------------------------------------
// FIFO queue with delete: shared package
// Sizes, field types, command and status codes, and ring address helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fqd_pkg;

   localparam int DEPTH = 16;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam int HANDLE_W = 32;
   localparam int CMD_W = 2;
   localparam int STATUS_W = 2;
   localparam int ENTRY_COUNT_W = 5;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [HANDLE_W-1:0] handle_type;
   typedef logic [CMD_W-1:0] cmd_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [ENTRY_COUNT_W-1:0] entry_count_type;

   localparam cmd_type CMD_ENQUEUE = 2'd0;
   localparam cmd_type CMD_DEQUEUE = 2'd1;
   localparam cmd_type CMD_DELETE = 2'd2;
   localparam cmd_type CMD_COUNT = 2'd3;

   localparam status_type STATUS_OK = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_FULL = 2'd2;

   // Physical slot of logical position off, counted from the head slot.
   function automatic addr_type wrap_add(addr_type base, cnt_type off);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         sum = sum - (CNT_W + 1)'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

/* hw/rtl/fqd_req_if.sv */
// ----------------------------------------------------------------------------
// FIFO queue with delete: command channel
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fqd_req_if;

   logic                 valid;
   logic                 ready;
   fqd_pkg::cmd_type     cmd;
   fqd_pkg::handle_type  handle_in;

   modport source (output valid, output cmd, output handle_in, input ready);
   modport sink (input valid, input cmd, input handle_in, output ready);

endinterface

/* hw/rtl/fqd_rsp_if.sv */
// ----------------------------------------------------------------------------
// FIFO queue with delete: result channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fqd_rsp_if;

   logic                      valid;
   logic                      ready;
   fqd_pkg::status_type       status;
   fqd_pkg::handle_type       handle_out;
   fqd_pkg::entry_count_type  entry_count;

   modport source (output valid, output status, output handle_out, output entry_count,
                   input ready);
   modport sink (input valid, input status, input handle_out, input entry_count,
                 output ready);

endinterface

/* hw/rtl/fqd_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fqd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/fifo_queue_with_delete.sv */
// ----------------------------------------------------------------------------
// FIFO queue with delete by value
// Enqueue, count and rejected commands go from ST_IDLE to ST_DONE; dequeue reads the
// head slot in ST_DEQ first. Delete runs ST_SCAN: one RAM read per stored entry, each
// entry behind the match written back one slot lower in the same pass.
// A new command is accepted only in ST_IDLE; it may enter while a result waits.
// Synchronous reset empties the queue; slot contents are left as they are.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fifo_queue_with_delete_macros.svh"

module fifo_queue_with_delete (
   input  logic       clock,
   input  logic       reset,
   fqd_req_if.sink    req_ch,
   fqd_rsp_if.source  rsp_ch
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DEQ = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]                state_ff, state_in;
   fqd_pkg::addr_type         head_ff, head_in;
   fqd_pkg::cnt_type          count_ff, count_in;
   fqd_pkg::cnt_type          rd_pos_ff, rd_pos_in;
   fqd_pkg::cnt_type          cmp_pos_ff, cmp_pos_in;
   logic                      pipe_vld_ff, pipe_vld_in;
   logic                      found_ff, found_in;
   fqd_pkg::handle_type       key_ff, key_in;
   fqd_pkg::status_type       res_status_ff, res_status_in;
   fqd_pkg::handle_type       res_handle_ff, res_handle_in;
   logic                      rsp_vld_ff, rsp_vld_in;
   fqd_pkg::status_type       rsp_status_ff, rsp_status_in;
   fqd_pkg::handle_type       rsp_handle_ff, rsp_handle_in;
   fqd_pkg::entry_count_type  rsp_count_ff, rsp_count_in;

   logic                 req_fire;
   logic                 rsp_free;
   logic                 scan_issue;
   logic                 ram_we;
   fqd_pkg::addr_type    ram_waddr;
   fqd_pkg::handle_type  ram_wdata;
   fqd_pkg::addr_type    ram_raddr;
   fqd_pkg::handle_type  ram_rdata;

   fqd_ram #(
      .WIDTH (fqd_pkg::HANDLE_W),
      .DEPTH (fqd_pkg::DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_vld_ff || rsp_ch.ready;
   assign scan_issue = (rd_pos_ff < count_ff);

   always_comb begin
      state_in = state_ff;
      head_in = head_ff;
      count_in = count_ff;
      rd_pos_in = rd_pos_ff;
      cmp_pos_in = cmp_pos_ff;
      pipe_vld_in = pipe_vld_ff;
      found_in = found_ff;
      key_in = key_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_count_in = rsp_count_ff;
      ram_we = 1'b0;
      ram_waddr = fqd_pkg::wrap_add(head_ff, count_ff);
      ram_wdata = req_ch.handle_in;
      ram_raddr = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_status_in = fqd_pkg::STATUS_OK;
               res_handle_in = '0;
               state_in = ST_DONE;
               case (req_ch.cmd)
                  fqd_pkg::CMD_ENQUEUE: begin
                     if (count_ff == fqd_pkg::cnt_type'(fqd_pkg::DEPTH)) begin
                        res_status_in = fqd_pkg::STATUS_FULL;
                     end else begin
                        ram_we = 1'b1;
                        count_in = count_ff + fqd_pkg::cnt_type'(1);
                     end
                  end
                  fqd_pkg::CMD_DEQUEUE: begin
                     if (count_ff == '0) begin
                        res_status_in = fqd_pkg::STATUS_EMPTY;
                     end else begin
                        state_in = ST_DEQ;
                     end
                  end
                  fqd_pkg::CMD_DELETE: begin
                     if ((count_ff == '0) || (req_ch.handle_in == '0)) begin
                        res_status_in = fqd_pkg::STATUS_EMPTY;
                     end else begin
                        key_in = req_ch.handle_in;
                        rd_pos_in = '0;
                        pipe_vld_in = 1'b0;
                        found_in = 1'b0;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DEQ: begin
            res_handle_in = ram_rdata;
            head_in = fqd_pkg::wrap_add(head_ff, fqd_pkg::cnt_type'(1));
            count_in = count_ff - fqd_pkg::cnt_type'(1);
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            ram_raddr = fqd_pkg::wrap_add(head_ff, rd_pos_ff);
            pipe_vld_in = scan_issue;
            cmp_pos_in = rd_pos_ff;
            if (scan_issue) begin
               rd_pos_in = rd_pos_ff + fqd_pkg::cnt_type'(1);
            end
            if (pipe_vld_ff) begin
               if (found_ff) begin
                  ram_we = 1'b1;
                  ram_waddr = fqd_pkg::wrap_add(head_ff, cmp_pos_ff - fqd_pkg::cnt_type'(1));
                  ram_wdata = ram_rdata;
               end else if (ram_rdata == key_ff) begin
                  found_in = 1'b1;
               end
               if (cmp_pos_ff == count_ff - fqd_pkg::cnt_type'(1)) begin
                  pipe_vld_in = 1'b0;
                  state_in = ST_DONE;
                  res_handle_in = '0;
                  if (found_ff || (ram_rdata == key_ff)) begin
                     res_status_in = fqd_pkg::STATUS_OK;
                     count_in = count_ff - fqd_pkg::cnt_type'(1);
                  end else begin
                     res_status_in = fqd_pkg::STATUS_EMPTY;
                  end
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_vld_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_handle_in = res_handle_ff;
               rsp_count_in = fqd_pkg::entry_count_type'(count_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff <= '0;
         count_ff <= '0;
         rd_pos_ff <= '0;
         pipe_vld_ff <= 1'b0;
         found_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         count_ff <= count_in;
         rd_pos_ff <= rd_pos_in;
         pipe_vld_ff <= pipe_vld_in;
         found_ff <= found_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_pos_ff <= cmp_pos_in;
      key_ff <= key_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_ch.valid = rsp_vld_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.handle_out = rsp_handle_ff;
   assign rsp_ch.entry_count = rsp_count_ff;

   `FQD_ASSERT_HOLDS(a_count_bound, clock, reset, 1'b1,
      count_ff <= fqd_pkg::cnt_type'(fqd_pkg::DEPTH))
   `FQD_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_fire, state_ff != ST_IDLE)
   `FQD_ASSERT_HOLDS(a_full_count, clock, reset,
      rsp_vld_ff && (rsp_status_ff == fqd_pkg::STATUS_FULL),
      rsp_count_ff == fqd_pkg::entry_count_type'(fqd_pkg::DEPTH))
   `FQD_ASSERT_HOLDS(a_err_no_handle, clock, reset,
      rsp_vld_ff && (rsp_status_ff != fqd_pkg::STATUS_OK), rsp_handle_ff == '0)

endmodule
